// ===== sv/lbc_pkg.sv =====
package lbc_pkg;

  localparam int BYTE_W          = 8;
  localparam int CODE_WORD_W     = 12;
  localparam int OUT_TDATA_W     = 16;
  localparam int FIRST_FREE_CODE = 257;

  // controller to datapath
  typedef struct packed {
    logic load;        // take in the accepted item's byte and final flag
    logic set_first;   // first byte of a stream becomes the phrase
    logic scan_start;  // rewind the dictionary scan
    logic scan_run;    // issue the next dictionary read
    logic take_hit;    // phrase becomes the matching code
    logic push_miss;   // emit phrase, add pair while the dictionary has room, restart phrase from byte
    logic push_last;   // emit phrase as stream end, reset for next stream
  } lbc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic phrase_valid;
    logic last;
    logic hit;
    logic miss;
    logic can_push;
  } lbc_stat_t;

endpackage

// ===== sv/lbc_ctrl.sv =====
module lbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  input  lbc_pkg::lbc_stat_t stat,
  output lbc_pkg::lbc_cmd_t  cmd
);
  import lbc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_MISS = 4'b0100,
    S_LAST = 4'b1000
  } lbc_state_t;

  lbc_state_t state_r, state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (!stat.phrase_valid) begin
            cmd.set_first = 1'b1;
            if (in_tlast) state_nxt = S_LAST;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = stat.last ? S_LAST : S_IDLE;
        end else if (stat.miss) begin
          state_nxt = S_MISS;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_MISS: begin
        if (stat.can_push) begin
          cmd.push_miss = 1'b1;
          state_nxt     = stat.last ? S_LAST : S_IDLE;
        end
      end
      S_LAST: begin
        if (stat.can_push) begin
          cmd.push_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/lbc_datapath.sv =====
module lbc_datapath #(
  parameter int DICT_ENTRIES = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lbc_pkg::BYTE_W-1:0]      in_byte,
  input  logic                            in_last,
  input  lbc_pkg::lbc_cmd_t               cmd,
  output lbc_pkg::lbc_stat_t              stat,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lbc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import lbc_pkg::*;

  localparam int CODE_W  = $clog2(DICT_ENTRIES);
  localparam int NFC_W   = $clog2(DICT_ENTRIES + 1);
  localparam int ENTRY_W = CODE_W + BYTE_W;
  localparam logic [NFC_W-1:0] FIRST_FREE = NFC_W'(FIRST_FREE_CODE);
  localparam logic [NFC_W-1:0] DICT_LIMIT = NFC_W'(DICT_ENTRIES);

  // dictionary: {prefix code, byte} at the phrase's code
  logic [ENTRY_W-1:0] mem [DICT_ENTRIES];
  logic [ENTRY_W-1:0] rd_data_r;

  logic [BYTE_W-1:0]      byte_r;
  logic                   last_r;
  logic [CODE_W-1:0]      cur_r, cur_nxt;
  logic                   phrase_valid_r, phrase_valid_nxt;
  logic [NFC_W-1:0]       nfc_r, nfc_nxt;
  logic [NFC_W-1:0]       scan_addr_r, scan_addr_nxt;
  logic [CODE_W-1:0]      chk_code_r, chk_code_nxt;
  logic                   chk_valid_r, chk_valid_nxt;
  logic                   rd_en;
  logic                   wr_en;
  logic                   push;
  logic                   out_valid_r, out_valid_nxt;
  logic [CODE_WORD_W-1:0] out_code_r;
  logic                   out_end_r;
  logic [ENTRY_W-1:0]     key;

  assign key   = {cur_r, byte_r};
  assign rd_en = cmd.scan_run && (scan_addr_r < nfc_r);
  assign wr_en = cmd.push_miss && (nfc_r < DICT_LIMIT);
  assign push  = cmd.push_miss || cmd.push_last;

  assign stat.phrase_valid = phrase_valid_r;
  assign stat.last         = last_r;
  assign stat.hit          = chk_valid_r && (rd_data_r == key);
  assign stat.miss         = !chk_valid_r && (scan_addr_r >= nfc_r);
  assign stat.can_push     = !out_valid_r || out_tready;

  always_comb begin
    cur_nxt          = cur_r;
    phrase_valid_nxt = phrase_valid_r;
    nfc_nxt          = nfc_r;
    scan_addr_nxt    = scan_addr_r;
    chk_code_nxt     = chk_code_r;
    chk_valid_nxt    = chk_valid_r;
    if (cmd.set_first) begin
      cur_nxt          = CODE_W'(in_byte);
      phrase_valid_nxt = 1'b1;
    end
    if (cmd.scan_start) begin
      scan_addr_nxt = FIRST_FREE;
      chk_valid_nxt = 1'b0;
    end
    if (cmd.scan_run) begin
      chk_valid_nxt = rd_en;
      if (rd_en) begin
        chk_code_nxt  = scan_addr_r[CODE_W-1:0];
        scan_addr_nxt = scan_addr_r + NFC_W'(1);
      end
    end
    if (cmd.take_hit) begin
      cur_nxt       = chk_code_r;
      chk_valid_nxt = 1'b0;
    end
    if (cmd.push_miss) begin
      cur_nxt = CODE_W'(byte_r);
      if (wr_en) nfc_nxt = nfc_r + NFC_W'(1);
    end
    if (cmd.push_last) begin
      cur_nxt          = '0;
      phrase_valid_nxt = 1'b0;
      nfc_nxt          = FIRST_FREE;
    end
    out_valid_nxt = push ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[nfc_r[CODE_W-1:0]] <= key;
    if (rd_en) rd_data_r <= mem[scan_addr_r[CODE_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r          <= '0;
      phrase_valid_r <= 1'b0;
      nfc_r          <= FIRST_FREE;
      chk_valid_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      cur_r          <= cur_nxt;
      phrase_valid_r <= phrase_valid_nxt;
      nfc_r          <= nfc_nxt;
      chk_valid_r    <= chk_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    chk_code_r  <= chk_code_nxt;
    if (cmd.load) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
    if (push) begin
      out_code_r <= CODE_WORD_W'(cur_r);
      out_end_r  <= cmd.push_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_code_r);
  assign out_tlast  = out_end_r;

`ifndef SYNTHESIS
  a_nfc_range: assert property (@(posedge clk) disable iff (!rst_n)
    nfc_r >= FIRST_FREE && nfc_r <= DICT_LIMIT)
    else $error("next free code out of range");

  a_phrase_known: assert property (@(posedge clk) disable iff (!rst_n)
    phrase_valid_r |-> (NFC_W'(cur_r) < nfc_r))
    else $error("current phrase is not a known code");

  a_stream_reset: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_last |=> (nfc_r == FIRST_FREE) && !phrase_valid_r && out_valid_r && out_end_r)
    else $error("stream end did not reset dictionary");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> stat.can_push)
    else $error("result pushed over a waiting item");
`endif

endmodule

// ===== sv/lzw_byte_compressor_top.sv =====
// channel | ports  | tdata (low bit up)       | tlast
// in      | in_*   | data_byte[7:0]           | final_byte
// out     | out_*  | code_word[11:0], zeros   | stream_end
//
// one item at a time; a byte that misses waits for the linear scan of codes 257 up to next_free_code,
// one read per cycle, and a final byte also waits for its stream-end push
// a result waits in the output register while the next item is accepted
// reset: synchronous active-low rst_n; no clearing pass, stale entries lie beyond the scan
// a stalled output holds the block only when a new result must be pushed
module lzw_byte_compressor_top #(
  parameter int DICT_ENTRIES = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lbc_pkg::BYTE_W-1:0]      in_tdata,   // data_byte[7:0]
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lbc_pkg::OUT_TDATA_W-1:0] out_tdata,  // code_word[11:0], pad[15:12]
  output logic                            out_tlast
);
  import lbc_pkg::*;

  lbc_cmd_t  cmd;
  lbc_stat_t stat;

  lbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lbc_datapath #(
    .DICT_ENTRIES (DICT_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sim/tb_lzw_byte_compressor_top.sv =====
module tb_lzw_byte_compressor_top;

  import lbc_pkg::*;

  // small dictionary so that it fills up within a short run
  localparam int DICT_DEPTH = 270;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 2 * (DICT_DEPTH - FIRST_FREE_CODE) + 20;
  localparam int ITEMS_PER_PHASE = 38;
  localparam int N_DIRECTED = 25;

  typedef struct packed {
    logic [CODE_WORD_W-1:0] code;
    logic                   fin;
  } code_item_t;

  typedef struct packed {
    logic [15:0]       prefix;
    logic [BYTE_W-1:0] sym;
  } pair_t;

  typedef struct packed {
    logic                   on;
    logic [CODE_WORD_W-1:0] code;
  } stated_t;

  typedef struct packed {
    logic [BYTE_W-1:0]      b;
    logic                   fin;
    logic                   stated;
    logic [CODE_WORD_W-1:0] code;
  } dir_row_t;

  // one-byte streams carry their code as typed in, the rest is predicted
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{8'h00, 1'b1, 1'b1, 12'd0},
    '{8'hFF, 1'b1, 1'b1, 12'd255},
    // repeating pair, phrases get extended by dictionary hits
    '{8'h41, 1'b0, 1'b0, 12'd0},
    '{8'h42, 1'b0, 1'b0, 12'd0},
    '{8'h41, 1'b0, 1'b0, 12'd0},
    '{8'h42, 1'b0, 1'b0, 12'd0},
    '{8'h41, 1'b0, 1'b0, 12'd0},
    '{8'h42, 1'b1, 1'b0, 12'd0},
    // final byte on a miss gives two codes
    '{8'h80, 1'b0, 1'b0, 12'd0},
    '{8'h7F, 1'b1, 1'b0, 12'd0},
    // all distinct bytes, fills the dictionary and misses once more
    '{8'h01, 1'b0, 1'b0, 12'd0},
    '{8'h02, 1'b0, 1'b0, 12'd0},
    '{8'h04, 1'b0, 1'b0, 12'd0},
    '{8'h08, 1'b0, 1'b0, 12'd0},
    '{8'h10, 1'b0, 1'b0, 12'd0},
    '{8'h20, 1'b0, 1'b0, 12'd0},
    '{8'h40, 1'b0, 1'b0, 12'd0},
    '{8'h81, 1'b0, 1'b0, 12'd0},
    '{8'hFE, 1'b0, 1'b0, 12'd0},
    '{8'hFD, 1'b0, 1'b0, 12'd0},
    '{8'hFB, 1'b0, 1'b0, 12'd0},
    '{8'hF7, 1'b0, 1'b0, 12'd0},
    '{8'hEF, 1'b0, 1'b0, 12'd0},
    '{8'hDF, 1'b0, 1'b0, 12'd0},
    '{8'hBF, 1'b1, 1'b0, 12'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned streams_sent = 0;
  int unsigned codes_checked = 0;
  int unsigned full_misses = 0;
  int unsigned dict_hits = 0;

  // compressor model state
  pair_t       dict_model [DICT_DEPTH];
  int unsigned model_next_free = FIRST_FREE_CODE;
  logic [15:0] model_phrase = '0;
  bit          model_started = 1'b0;

  code_item_t code_q[$];
  stated_t    stated_q[$];

  lzw_byte_compressor_top #(
    .DICT_ENTRIES(DICT_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic compress_byte(input logic [BYTE_W-1:0] b, input logic fin);
    bit          found;
    int unsigned hit_code;
    found = 1'b0;
    hit_code = 0;
    if (!model_started) begin
      model_phrase = 16'(b);
      model_started = 1'b1;
    end else begin
      for (int unsigned k = FIRST_FREE_CODE; k < model_next_free && k < DICT_DEPTH; k++) begin
        if (!found && dict_model[k] == {model_phrase, b}) begin
          found = 1'b1;
          hit_code = k;
        end
      end
      if (found) begin
        model_phrase = 16'(hit_code);
        dict_hits++;
      end else begin
        code_q.push_back('{model_phrase[CODE_WORD_W-1:0], 1'b0});
        if (model_next_free < DICT_DEPTH) begin
          dict_model[model_next_free] = '{model_phrase, b};
          model_next_free++;
        end else begin
          full_misses++;
        end
        model_phrase = 16'(b);
      end
    end
    if (fin) begin
      code_q.push_back('{model_phrase[CODE_WORD_W-1:0], 1'b1});
      model_next_free = FIRST_FREE_CODE;
      model_phrase = '0;
      model_started = 1'b0;
    end
  endtask

  always @(posedge clk) begin : watch_ports
    stated_t    st;
    code_item_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        st = stated_q.pop_front();
        compress_byte(in_tdata, in_tlast);
        if (st.on) begin
          void'(code_q.pop_back());
          code_q.push_back('{st.code, 1'b1});
        end
      end
      if (out_tvalid && out_tready) begin
        if (code_q.size() == 0) begin
          $error("unexpected code: code_word %0d, stream_end %0b",
                 out_tdata[CODE_WORD_W-1:0], out_tlast);
          mismatches++;
        end else begin
          want = code_q.pop_front();
          codes_checked++;
          if (out_tdata[CODE_WORD_W-1:0] !== want.code) begin
            $error("code_word: expected %0d, got %0d", want.code,
                   out_tdata[CODE_WORD_W-1:0]);
            mismatches++;
          end
          if (out_tlast !== want.fin) begin
            $error("stream_end: expected %0b, got %0b", want.fin, out_tlast);
            mismatches++;
          end
          if (out_tdata[OUT_TDATA_W-1:CODE_WORD_W] !== '0) begin
            $error("pad: expected 0, got %0h", out_tdata[OUT_TDATA_W-1:CODE_WORD_W]);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin,
                           input logic stated, input logic [CODE_WORD_W-1:0] code);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    stated_q.push_back('{stated, code});
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (fin) streams_sent++;
  endtask

  // mostly a few symbols so phrases repeat, sometimes any byte value
  task automatic send_random_stream(input int unsigned max_len);
    int unsigned       len;
    int unsigned       n_syms;
    bit                any_byte;
    logic [BYTE_W-1:0] syms [4];
    logic [BYTE_W-1:0] b;
    any_byte = ($urandom_range(9) < 3);
    len = ($urandom_range(5) == 0) ? $urandom_range(60, 30) : $urandom_range(20, 1);
    if (len > max_len) len = max_len;
    n_syms = $urandom_range(4, 2);
    foreach (syms[k]) syms[k] = BYTE_W'($urandom);
    for (int unsigned k = 0; k < len; k++) begin
      b = any_byte ? BYTE_W'($urandom) : syms[$urandom_range(n_syms - 1)];
      send_byte(b, k == len - 1, 1'b0, '0);
    end
  endtask

  initial begin : run
    int unsigned phase_start;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 3; p++) begin
      src_idle_pct = (p == 0) ? 32 : (p == 1) ? 54 : 0;
      sink_idle_pct = (p == 0) ? 54 : (p == 1) ? 32 : 0;
      if (p == 0) begin
        for (int k = 0; k < N_DIRECTED; k++) begin
          send_byte(DIRECTED[k].b, DIRECTED[k].fin, DIRECTED[k].stated, DIRECTED[k].code);
        end
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < ITEMS_PER_PHASE)
        send_random_stream(ITEMS_PER_PHASE - (bytes_sent - phase_start));
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (code_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes in %0d streams, %0d codes checked", bytes_sent, streams_sent,
             codes_checked);
    $display("%0d dictionary hits, %0d misses with the dictionary full", dict_hits,
             full_misses);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
